// ===== rtl/core/mcl_pkg.sv =====
// Package for the covering lower bound block: defaults, action and command codes,
// controller states and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mcl_pkg;

  localparam int unsigned MAX_ROWS_DEF  = 64;
  localparam int unsigned MAX_COLS_DEF  = 64;
  localparam int unsigned COST_BITS_DEF = 16;

  localparam int unsigned IDX_BITS    = 8;
  localparam int unsigned BOUND_BITS  = 22;
  localparam int unsigned CHOSEN_BITS = 7;

  localparam logic [BOUND_BITS-1:0]  BOUND_MAX  = '1;
  localparam logic [CHOSEN_BITS-1:0] CHOSEN_MAX = '1;

  typedef enum logic [1:0] {
    ACT_CLEAR,
    ACT_CELL,
    ACT_COST,
    ACT_COMPUTE
  } act_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_CELL_RD,
    OP_COST,
    OP_START,
    OP_RD_ROWA,
    OP_RD_ROWB,
    OP_WR_ADJ,
    OP_SEARCH_INIT,
    OP_RD_DEG,
    OP_RD_BEST,
    OP_RD_COST,
    OP_ADD,
    OP_RM_J,
    OP_RD_DEG2,
    OP_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CELL,
    ST_B_ROWI,
    ST_B_ROWJ,
    ST_B_DRAIN,
    ST_B_WRITE,
    ST_S_INIT,
    ST_S_SCAN,
    ST_S_DRAIN,
    ST_S_CHECK,
    ST_C_SCAN,
    ST_C_DRAIN,
    ST_C_ADD,
    ST_R_LOAD,
    ST_R_SCAN,
    ST_D_LOAD,
    ST_D_SCAN,
    ST_D_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e              op;
    logic [IDX_BITS-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic qual;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/mcl_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mcl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcl_ctrl.sv =====
// Sequencer of the greedy walk: state machine and loop counters.
// Depends on mcl_pkg; drives the datapath by commands and reads its status.
`timescale 1ns / 1ps
`default_nettype none
module mcl_ctrl #(
  parameter int unsigned MAX_ROWS = mcl_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = mcl_pkg::MAX_COLS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [1:0]                    action_i,
  output logic                               in_stall_o,
  input  wire mcl_pkg::dp_status_t           status_i,
  output mcl_pkg::dp_cmd_t                   cmd_o,
  output logic [mcl_pkg::IDX_BITS-1:0]       row_sel_o
);
  import mcl_pkg::*;

  localparam logic [IDX_BITS-1:0] LAST_ROW = IDX_BITS'(MAX_ROWS - 1);
  localparam logic [IDX_BITS-1:0] LAST_COL = IDX_BITS'(MAX_COLS - 1);

  ctrl_state_e state_q, state_d;
  logic [IDX_BITS-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign row_sel_o = j_q;

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    cmd_o.op   = OP_NOP;
    cmd_o.idx  = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (act_e'(action_i))
            ACT_CLEAR: cmd_o.op = OP_CLEAR;
            ACT_CELL: begin
              cmd_o.op = OP_CELL_RD;
              state_d  = ST_CELL;
            end
            ACT_COST: cmd_o.op = OP_COST;
            ACT_COMPUTE: begin
              cmd_o.op = OP_START;
              i_d      = '0;
              state_d  = ST_B_ROWI;
            end
            default: cmd_o.op = OP_NOP;
          endcase
        end
      end
      ST_CELL: state_d = ST_IDLE;
      ST_B_ROWI: begin
        cmd_o.op  = OP_RD_ROWA;
        cmd_o.idx = i_q;
        j_d       = '0;
        state_d   = ST_B_ROWJ;
      end
      ST_B_ROWJ: begin
        cmd_o.op  = OP_RD_ROWB;
        cmd_o.idx = j_q;
        if (j_q == LAST_ROW) begin
          state_d = ST_B_DRAIN;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_B_DRAIN: state_d = ST_B_WRITE;
      ST_B_WRITE: begin
        cmd_o.op  = OP_WR_ADJ;
        cmd_o.idx = i_q;
        if (i_q == LAST_ROW) begin
          state_d = ST_S_INIT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_B_ROWI;
        end
      end
      ST_S_INIT: begin
        cmd_o.op = OP_SEARCH_INIT;
        k_d      = '0;
        state_d  = ST_S_SCAN;
      end
      ST_S_SCAN: begin
        cmd_o.op  = OP_RD_DEG;
        cmd_o.idx = k_q;
        if (k_q == LAST_ROW) begin
          state_d = ST_S_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_S_DRAIN: state_d = ST_S_CHECK;
      ST_S_CHECK: begin
        if (status_i.found) begin
          cmd_o.op = OP_RD_BEST;
          k_d      = '0;
          state_d  = ST_C_SCAN;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_C_SCAN: begin
        cmd_o.op  = OP_RD_COST;
        cmd_o.idx = k_q;
        if (k_q == LAST_COL) begin
          state_d = ST_C_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_C_DRAIN: state_d = ST_C_ADD;
      ST_C_ADD: begin
        cmd_o.op = OP_ADD;
        j_d      = '0;
        state_d  = ST_R_LOAD;
      end
      ST_R_LOAD: state_d = ST_R_SCAN;
      ST_R_SCAN: begin
        cmd_o.idx = j_q;
        if (status_i.qual) begin
          cmd_o.op = OP_RM_J;
          k_d      = '0;
          state_d  = ST_D_LOAD;
        end else if (j_q == LAST_ROW) begin
          state_d = ST_S_INIT;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_D_LOAD: state_d = ST_D_SCAN;
      ST_D_SCAN: begin
        cmd_o.op  = OP_RD_DEG2;
        cmd_o.idx = k_q;
        if (k_q == LAST_ROW) begin
          state_d = ST_D_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_D_DRAIN: begin
        if (j_q == LAST_ROW) begin
          state_d = ST_S_INIT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_R_SCAN;
        end
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcl_dp.sv =====
// Datapath: matrix, cost, adjacency and degree memories, removal flags, running
// sums and the result register. Depends on mcl_pkg and mcl_ram.
`timescale 1ns / 1ps
`default_nettype none
module mcl_dp #(
  parameter int unsigned MAX_ROWS  = mcl_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS  = mcl_pkg::MAX_COLS_DEF,
  parameter int unsigned COST_BITS = mcl_pkg::COST_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mcl_pkg::dp_cmd_t                  cmd_i,
  input  wire logic [mcl_pkg::IDX_BITS-1:0]      row_sel_i,
  output mcl_pkg::dp_status_t                    status_o,
  input  wire logic [5:0]                        row_index_i,
  input  wire logic [5:0]                        col_index_i,
  input  wire logic [15:0]                       cost_value_i,
  input  wire logic                              out_stall_i,
  output logic                                   out_valid_o,
  output logic [mcl_pkg::BOUND_BITS-1:0]         lower_bound_o,
  output logic [mcl_pkg::CHOSEN_BITS-1:0]        rows_chosen_o
);
  import mcl_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned DW = $clog2(MAX_ROWS + 1);

  dp_op_e                op_q;
  logic [IDX_BITS-1:0]   idx_q;
  logic [MAX_ROWS-1:0]   cov_valid_q, removed_q, adj_acc_q, adj_best_q, adj_j_q;
  logic [MAX_COLS-1:0]   cost_valid_q, row_a_q, best_row_q;
  logic                  cov_ok_q, cost_ok_q, cell_ok_q, found_q, out_valid_q;
  logic [RW-1:0]         cell_row_q, best_q;
  logic [CW-1:0]         cell_col_q;
  logic [DW-1:0]         deg_acc_q, best_deg_q;
  logic [COST_BITS-1:0]  min_q;
  logic [BOUND_BITS-1:0] sum_q, lb_q;
  logic [CHOSEN_BITS-1:0] chosen_q, rc_q;

  logic [RW-1:0]        ri, ri_q, cov_raddr, adj_raddr, deg_waddr;
  logic [CW-1:0]        ci_q, col_a;
  logic [MAX_COLS-1:0]  cov_rdata, cov_row, cov_wdata;
  logic [COST_BITS-1:0] cost_rdata, cost_row;
  logic [MAX_ROWS-1:0]  adj_rdata;
  logic [DW-1:0]        deg_rdata, deg_wdata;
  logic                 cov_we, cost_we, deg_we, cell_ok, col_ok, hit;
  logic [32:0]          sum_ext;

  assign ri      = cmd_i.idx[RW-1:0];
  assign ri_q    = idx_q[RW-1:0];
  assign ci_q    = idx_q[CW-1:0];
  assign col_a   = CW'(col_index_i);
  assign col_ok  = 32'(col_index_i) < MAX_COLS;
  assign cell_ok = (32'(row_index_i) < MAX_ROWS) && col_ok;

  always_comb begin
    case (cmd_i.op)
      OP_CELL_RD: cov_raddr = RW'(row_index_i);
      OP_RD_BEST: cov_raddr = best_q;
      default:    cov_raddr = ri;
    endcase
  end

  assign adj_raddr = (cmd_i.op == OP_ADD) ? best_q : ri;
  assign cov_row   = cov_ok_q ? cov_rdata : '0;
  assign cost_row  = cost_ok_q ? cost_rdata : '0;
  assign cov_we    = (op_q == OP_CELL_RD) && cell_ok_q;
  assign cov_wdata = cov_row | (MAX_COLS'(1) << cell_col_q);
  assign cost_we   = (cmd_i.op == OP_COST) && col_ok;
  assign hit       = |(row_a_q & cov_row);
  assign sum_ext   = 33'(sum_q) + 33'(min_q);

  always_comb begin
    deg_we    = 1'b0;
    deg_waddr = ri;
    deg_wdata = deg_acc_q;
    if (cmd_i.op == OP_WR_ADJ) begin
      deg_we = 1'b1;
    end else if ((op_q == OP_RD_DEG2) && adj_j_q[ri_q] && (deg_rdata != '0)) begin
      deg_we    = 1'b1;
      deg_waddr = ri_q;
      deg_wdata = deg_rdata - 1'b1;
    end
  end

  mcl_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_cover_ram (
    .clk_i, .we_i(cov_we), .waddr_i(cell_row_q), .wdata_i(cov_wdata),
    .raddr_i(cov_raddr), .rdata_o(cov_rdata)
  );

  mcl_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_COLS)) u_cost_ram (
    .clk_i, .we_i(cost_we), .waddr_i(col_a), .wdata_i(COST_BITS'(cost_value_i)),
    .raddr_i(cmd_i.idx[CW-1:0]), .rdata_o(cost_rdata)
  );

  mcl_ram #(.WIDTH(MAX_ROWS), .DEPTH(MAX_ROWS)) u_adj_ram (
    .clk_i, .we_i(cmd_i.op == OP_WR_ADJ), .waddr_i(ri), .wdata_i(adj_acc_q),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  mcl_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_deg_ram (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wdata),
    .raddr_i(ri), .rdata_o(deg_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= OP_NOP;
      idx_q        <= '0;
      cov_valid_q  <= '0;
      cost_valid_q <= '0;
      cov_ok_q     <= 1'b0;
      cost_ok_q    <= 1'b0;
      cell_ok_q    <= 1'b0;
      cell_row_q   <= '0;
      cell_col_q   <= '0;
      removed_q    <= '0;
      row_a_q      <= '0;
      adj_acc_q    <= '0;
      deg_acc_q    <= '0;
      found_q      <= 1'b0;
      best_q       <= '0;
      best_deg_q   <= '0;
      best_row_q   <= '0;
      min_q        <= '0;
      sum_q        <= '0;
      chosen_q     <= '0;
      adj_best_q   <= '0;
      adj_j_q      <= '0;
      out_valid_q  <= 1'b0;
      lb_q         <= '0;
      rc_q         <= '0;
    end else begin
      op_q      <= cmd_i.op;
      idx_q     <= cmd_i.idx;
      cov_ok_q  <= cov_valid_q[cov_raddr];
      cost_ok_q <= cost_valid_q[cmd_i.idx[CW-1:0]];
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (op_q)
        OP_CELL_RD: begin
          if (cell_ok_q) begin
            cov_valid_q[cell_row_q] <= 1'b1;
          end
        end
        OP_RD_ROWA: begin
          row_a_q   <= cov_row;
          adj_acc_q <= '0;
          deg_acc_q <= '0;
        end
        OP_RD_ROWB: begin
          adj_acc_q[ri_q] <= hit;
          deg_acc_q       <= deg_acc_q + DW'(hit);
        end
        OP_RD_DEG: begin
          if (!removed_q[ri_q] && (!found_q || (deg_rdata < best_deg_q))) begin
            found_q    <= 1'b1;
            best_q     <= ri_q;
            best_deg_q <= deg_rdata;
          end
        end
        OP_RD_BEST: best_row_q <= cov_row;
        OP_RD_COST: begin
          if (best_row_q[ci_q] && (cost_row < min_q)) begin
            min_q <= cost_row;
          end
        end
        OP_ADD:  adj_best_q <= adj_rdata;
        OP_RM_J: adj_j_q    <= adj_rdata;
        default: ;
      endcase

      case (cmd_i.op)
        OP_CLEAR: cov_valid_q <= '0;
        OP_CELL_RD: begin
          cell_ok_q  <= cell_ok;
          cell_row_q <= RW'(row_index_i);
          cell_col_q <= col_a;
        end
        OP_COST: begin
          if (col_ok) begin
            cost_valid_q[col_a] <= 1'b1;
          end
        end
        OP_START: begin
          sum_q    <= '0;
          chosen_q <= '0;
        end
        OP_WR_ADJ:      removed_q[ri] <= ~|row_a_q;
        OP_SEARCH_INIT: found_q <= 1'b0;
        OP_RD_BEST: begin
          removed_q[best_q] <= 1'b1;
          min_q             <= '1;
        end
        OP_ADD: begin
          sum_q <= (sum_ext > 33'(BOUND_MAX)) ? BOUND_MAX : sum_q + BOUND_BITS'(min_q);
          if (chosen_q != CHOSEN_MAX) begin
            chosen_q <= chosen_q + 1'b1;
          end
        end
        OP_RM_J: removed_q[ri] <= 1'b1;
        OP_OUT: begin
          out_valid_q <= 1'b1;
          lb_q        <= sum_q;
          rc_q        <= chosen_q;
        end
        default: ;
      endcase
    end
  end

  assign status_o.found    = found_q;
  assign status_o.qual     = adj_best_q[row_sel_i[RW-1:0]] && !removed_q[row_sel_i[RW-1:0]];
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign lower_bound_o = lb_q;
  assign rows_chosen_o = rc_q;

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_OUT) |-> !(out_valid_q && out_stall_i))
    else $error("Pending result overwritten.");

  a_pick_is_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_RD_BEST) |-> (found_q && !removed_q[best_q]))
    else $error("Picked row is already removed.");

  a_remove_neighbour_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_RM_J) |-> (adj_best_q[ri] && !removed_q[ri]))
    else $error("Removal of a row that is not a live neighbour.");

  a_deg_write_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_WR_ADJ) |-> (op_q != OP_RD_DEG2))
    else $error("Two degree writes in one cycle.");

endmodule
`default_nettype wire

// ===== rtl/core/mis_cover_lower_bound.sv =====
// Lower bound on the minimum cover cost by a greedy independent set of rows.
// Top level; depends on mcl_pkg, mcl_ctrl, mcl_dp and mcl_ram.
//
// The input channel carries one action per beat: clear the matrix, set a cell,
// set a column cost, or compute the bound. Clear and set cost are taken with no
// stall, and a set cell beat stalls the input through ST_CELL, since the row is
// read and written back. A compute beat holds the input stalled while the walk
// runs in its memories: it builds the adjacency and degrees, then for each pick
// runs a degree scan, a cost scan, a neighbour scan and one more degree scan per
// removed neighbour, and ends with a final degree scan. Each scan reads one
// memory word a cycle.
// The result beat appears on the output channel and is held while the output is
// stalled; load beats are still taken meanwhile, and a following compute waits
// at its end until the earlier result has gone.
// Reset clears the matrix and costs through valid bits, at once; no clearing
// pass is needed and the block takes beats in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module mis_cover_lower_bound #(
  parameter int unsigned MAX_ROWS  = mcl_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS  = mcl_pkg::MAX_COLS_DEF,
  parameter int unsigned COST_BITS = mcl_pkg::COST_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [5:0]                    row_index_i,
  input  wire logic [5:0]                    col_index_i,
  input  wire logic [15:0]                   cost_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mcl_pkg::BOUND_BITS-1:0]     lower_bound_o,
  output logic [mcl_pkg::CHOSEN_BITS-1:0]    rows_chosen_o
);
  import mcl_pkg::*;

  dp_cmd_t             cmd;
  dp_status_t          status;
  logic [IDX_BITS-1:0] row_sel;

  mcl_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .action_i, .in_stall_o,
    .status_i(status), .cmd_o(cmd), .row_sel_o(row_sel)
  );

  mcl_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .COST_BITS(COST_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .row_sel_i(row_sel), .status_o(status),
    .row_index_i, .col_index_i, .cost_value_i, .out_stall_i,
    .out_valid_o, .lower_bound_o, .rows_chosen_o
  );

endmodule
`default_nettype wire

// ===== bench/mis_cover_lower_bound_test.sv =====
// Testbench for mis_cover_lower_bound: drives load and compute beats, predicts each bound.
// Depends on mcl_pkg and the mis_cover_lower_bound RTL; needs no other files.
`timescale 1ns / 1ps
module mis_cover_lower_bound_test;
  import mcl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [21:0] bound;
    logic [6:0]  chosen;
  } bound_t;

  class bound_board;
    logic [63:0] cells [64];
    logic [15:0] costs [64];
    bound_t      pending [$];
    int          errors;
    int          computes;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (costs[i]) costs[i] = '0;
      errors = 0;
      computes = 0;
    endfunction

    function bound_t greedy_bound();
      logic [63:0] adj [64];
      int          deg [64];
      bit          gone [64];
      int          best;
      int          best_deg;
      int          cheapest;
      longint      sum;
      int          picks;
      bound_t      r;
      sum = 0;
      picks = 0;
      for (int i = 0; i < 64; i++) begin
        adj[i] = '0;
        for (int j = 0; j < 64; j++) begin
          if (|(cells[i] & cells[j])) adj[i][j] = 1'b1;
        end
        deg[i] = $countones(adj[i]);
        gone[i] = (cells[i] == '0);
      end
      while (1) begin
        best = -1;
        best_deg = 32'h7fffffff;
        for (int i = 0; i < 64; i++) begin
          if (!gone[i] && deg[i] < best_deg) begin
            best_deg = deg[i];
            best = i;
          end
        end
        if (best < 0) break;
        cheapest = 32'h7fffffff;
        for (int c = 0; c < 64; c++) begin
          if (cells[best][c] && costs[c] < cheapest) cheapest = costs[c];
        end
        sum += cheapest;
        if (sum > 4194303) sum = 4194303;
        picks++;
        gone[best] = 1'b1;
        for (int j = 0; j < 64; j++) begin
          if (!adj[best][j] || gone[j]) continue;
          gone[j] = 1'b1;
          for (int k = 0; k < 64; k++) begin
            if (adj[j][k] && deg[k] > 0) deg[k]--;
          end
        end
      end
      r.bound = sum[21:0];
      r.chosen = (picks > 127) ? 7'd127 : picks[6:0];
      return r;
    endfunction

    function void note_beat(act_e act, logic [5:0] row, logic [5:0] col, logic [15:0] cost);
      case (act)
        ACT_CLEAR: begin
          foreach (cells[i]) cells[i] = '0;
        end
        ACT_CELL: begin
          cells[row][col] = 1'b1;
        end
        ACT_COST: begin
          costs[col] = cost;
        end
        default: begin
          pending.push_back(greedy_bound());
          computes++;
        end
      endcase
    endfunction

    function void check_result(logic [21:0] bound, logic [6:0] chosen);
      bound_t exp_r;
      if (pending.size() == 0) begin
        $error("result beat with no bound expected: lower_bound %0d rows_chosen %0d",
               bound, chosen);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (bound !== exp_r.bound) begin
        $error("lower_bound: expected %0d, got %0d", exp_r.bound, bound);
        errors++;
      end
      if (chosen !== exp_r.chosen) begin
        $error("rows_chosen: expected %0d, got %0d", exp_r.chosen, chosen);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [5:0]  row_index_i = '0;
  logic [5:0]  col_index_i = '0;
  logic [15:0] cost_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [21:0] lower_bound_o;
  logic [6:0]  rows_chosen_o;

  bound_board  board = new();
  bit          calm = 1'b0;
  int          cycles = 0;
  int          beats_sent = 0;

  mis_cover_lower_bound u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .row_index_i,
    .col_index_i,
    .cost_value_i,
    .out_valid_o,
    .out_stall_i,
    .lower_bound_o,
    .rows_chosen_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("mis_cover_lower_bound verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_beat(act_e'(action_i), row_index_i, col_index_i, cost_value_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(lower_bound_o, rows_chosen_o);
    end
  end

  initial begin
    @(negedge clk_i);
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(act_e act, int row, int col, int cost);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    row_index_i <= row[5:0];
    col_index_i <= col[5:0];
    cost_value_i <= cost[15:0];
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_problem();
    int span;
    int cells;
    span = ($urandom_range(0, 3) == 0) ? 64 : (($urandom_range(0, 1) == 0) ? 4 : 16);
    if ($urandom_range(0, 3) != 0) send_beat(ACT_CLEAR, $urandom_range(0, 63),
                                              $urandom_range(0, 63), $urandom);
    cells = $urandom_range(1, 30);
    repeat (cells) begin
      if ($urandom_range(0, 4) == 0) begin
        send_beat(ACT_COST, $urandom_range(0, 63), $urandom_range(0, span - 1),
                  ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 65535));
      end else begin
        send_beat(ACT_CELL, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
                  $urandom);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      send_beat(act_e'($urandom_range(0, 2)), $urandom_range(0, 63),
                $urandom_range(0, 63), $urandom);
    end
    send_beat(ACT_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_beat(ACT_COMPUTE, 0, 0, 0);
    send_beat(ACT_CELL, 0, 0, 0);
    send_beat(ACT_COMPUTE, 63, 63, 65535);
    send_beat(ACT_COST, 0, 0, 65535);
    send_beat(ACT_COST, 63, 63, 0);
    send_beat(ACT_CELL, 63, 63, 0);
    send_beat(ACT_CELL, 63, 0, 0);
    send_beat(ACT_CELL, 1, 63, 0);
    send_beat(ACT_COMPUTE, 0, 0, 0);
    send_beat(ACT_CLEAR, 63, 63, 65535);
    send_beat(ACT_COMPUTE, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_beat(ACT_CELL, i, i, 0);
    send_beat(ACT_COST, 0, 5, 12345);
    send_beat(ACT_COMPUTE, 0, 0, 0);

    while (beats_sent < 1650) begin
      if (beats_sent > 1450) calm = 1'b1;
      run_problem();
      if (board.computes == 30) begin
        in_valid_i <= 1'b0;
        wait (board.pending.size() == 0);
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    wait (board.pending.size() == 0);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d beats, %0d of them bound computations, under random stalls.",
             beats_sent, board.computes);
    if (board.errors == 0) begin
      $display("mis_cover_lower_bound verification clean");
    end else begin
      $display("mis_cover_lower_bound verification failed");
    end
    $finish;
  end

endmodule
